// ----- rtl/core/iee_pkg.sv -----
// Package for the infix expression evaluator: character codes, operator and
// state encodings, and the control structs of the shared multiply/divide unit.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package iee_pkg;

  localparam int WordWidthDefault = 32;
  localparam int ValueWidth       = 32;
  localparam int CharWidth        = 8;

  localparam logic [CharWidth-1:0] CharPlus   = 8'h2B;
  localparam logic [CharWidth-1:0] CharMinus  = 8'h2D;
  localparam logic [CharWidth-1:0] CharTimes  = 8'h2A;
  localparam logic [CharWidth-1:0] CharDivide = 8'h2F;
  localparam logic [CharWidth-1:0] CharSpace  = 8'h20;
  localparam logic [CharWidth-1:0] CharZero   = 8'h30;
  localparam logic [CharWidth-1:0] CharNine   = 8'h39;

  typedef enum logic [2:0] {
    OP_PLUS   = 3'd0,
    OP_MINUS  = 3'd1,
    OP_TIMES  = 3'd2,
    OP_DIVIDE = 3'd3,
    OP_OTHER  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_CLOSE,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } mdu_req_t;

  typedef struct packed {
    logic done;
    logic div_zero;
  } mdu_status_t;

  function automatic op_e op_code(input logic [CharWidth-1:0] code);
    op_e op;
    case (code)
      CharPlus:   op = OP_PLUS;
      CharMinus:  op = OP_MINUS;
      CharTimes:  op = OP_TIMES;
      CharDivide: op = OP_DIVIDE;
      default:    op = OP_OTHER;
    endcase
    return op;
  endfunction

endpackage

// ----- rtl/core/iee_if.sv -----
// Handshake channels of the evaluator: the character word in and the result
// word out, each with valid, ready and payload. Depends on iee_pkg.
`timescale 1ns / 1ps

interface iee_char_if import iee_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CharWidth-1:0] char_code;
  logic                 is_last;

  modport source (output valid, char_code, is_last, input ready);
  modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface iee_result_if import iee_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [ValueWidth-1:0] value;
  logic                         div_by_zero;

  modport source (output valid, value, div_by_zero, input ready);
  modport sink   (input valid, value, div_by_zero, output ready);
endinterface

// ----- rtl/core/iee_muldiv.sv -----
// Shared iterative unit: shift-add multiply or signed restoring divide, one
// bit per cycle. Depends on iee_pkg.
`timescale 1ns / 1ps

module iee_muldiv import iee_pkg::*; #(
  parameter int WORD_WIDTH = WordWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mdu_req_t              req_i,
  input  logic [WORD_WIDTH-1:0] a_i,
  input  logic [WORD_WIDTH-1:0] b_i,
  output logic [WORD_WIDTH-1:0] result_o,
  output mdu_status_t           status_o
);

  localparam int CW = $clog2(WORD_WIDTH + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  is_div_q, is_div_d;
  logic                  neg_q, neg_d;
  logic                  dz_q, dz_d;
  logic [WORD_WIDTH:0]   reg_a_q, reg_a_d;
  logic [WORD_WIDTH-1:0] reg_b_q, reg_b_d;
  logic [WORD_WIDTH-1:0] reg_c_q, reg_c_d;

  logic [WORD_WIDTH-1:0] mag_a, mag_b;
  logic [WORD_WIDTH:0]   rem_shift, trial;
  logic [WORD_WIDTH-1:0] mul_sum;

  always_comb begin
    mag_a     = a_i[WORD_WIDTH-1] ? (~a_i + 1'b1) : a_i;
    mag_b     = b_i[WORD_WIDTH-1] ? (~b_i + 1'b1) : b_i;
    rem_shift = {reg_a_q[WORD_WIDTH-1:0], reg_b_q[WORD_WIDTH-1]};
    trial     = rem_shift - {1'b0, reg_c_q};
    mul_sum   = reg_a_q[WORD_WIDTH-1:0] + (reg_c_q[0] ? reg_b_q : '0);
  end

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    dz_d     = dz_q;
    reg_a_d  = reg_a_q;
    reg_b_d  = reg_b_q;
    reg_c_d  = reg_c_q;
    if (req_i.start) begin
      busy_d   = 1'b1;
      cnt_d    = CW'(WORD_WIDTH);
      is_div_d = req_i.is_div;
      reg_a_d  = '0;
      if (req_i.is_div) begin
        reg_b_d = mag_a;
        reg_c_d = mag_b;
        neg_d   = a_i[WORD_WIDTH-1] ^ b_i[WORD_WIDTH-1];
        dz_d    = (b_i == '0);
      end else begin
        reg_b_d = a_i;
        reg_c_d = b_i;
        neg_d   = 1'b0;
        dz_d    = 1'b0;
      end
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
      if (is_div_q) begin
        if (!trial[WORD_WIDTH]) begin
          reg_a_d = trial;
          reg_b_d = {reg_b_q[WORD_WIDTH-2:0], 1'b1};
        end else begin
          reg_a_d = rem_shift;
          reg_b_d = {reg_b_q[WORD_WIDTH-2:0], 1'b0};
        end
      end else begin
        reg_a_d = {1'b0, mul_sum};
        reg_b_d = {reg_b_q[WORD_WIDTH-2:0], 1'b0};
        reg_c_d = {1'b0, reg_c_q[WORD_WIDTH-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    dz_q     <= dz_d;
    reg_a_q  <= reg_a_d;
    reg_b_q  <= reg_b_d;
    reg_c_q  <= reg_c_d;
  end

  always_comb begin
    if (!is_div_q) begin
      result_o = reg_a_q[WORD_WIDTH-1:0];
    end else if (dz_q) begin
      result_o = '0;
    end else if (neg_q) begin
      result_o = ~reg_b_q + 1'b1;
    end else begin
      result_o = reg_b_q;
    end
    status_o.done     = done_q;
    status_o.div_zero = dz_q & is_div_q;
  end

endmodule

// ----- rtl/core/infix_expression_evaluator_core.sv -----
// Top level of the infix expression evaluator: character sequencer, term and
// sum registers, and the shared multiply/divide unit. Depends on iee_pkg, iee_if and iee_muldiv.
// Digits, spaces and operators that close a pending + - or unknown are taken without a hold;
// an operator that closes a pending * or / holds the input while the multiply/divide unit runs.
// The closing word leads through CLOSE, BUSY with * or / pending, and FINISH; the input waits
// until the result word is registered. Reset clears the state and sets the operator to plus.
`timescale 1ns / 1ps

module infix_expression_evaluator_core import iee_pkg::*; #(
  parameter int WORD_WIDTH = WordWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  iee_char_if.sink      char_i,
  iee_result_if.source  result_o
);

  state_e                state_q, state_d;
  logic [WORD_WIDTH-1:0] sum_q, sum_d;
  logic [WORD_WIDTH-1:0] term_q, term_d;
  logic [WORD_WIDTH-1:0] num_q, num_d;
  op_e                   op_q, op_d;
  logic                  dz_q, dz_d;
  logic                  last_q, last_d;
  logic                  close_q, close_d;
  logic                  out_valid_q, out_valid_d;
  logic [ValueWidth-1:0] out_value_q, out_value_d;
  logic                  out_dz_q, out_dz_d;

  logic                  accept, is_digit, is_space, is_op, pend_muldiv;
  logic                  apply_en, out_free;
  op_e                   next_op;
  logic [WORD_WIDTH-1:0] digit_ext, total;
  logic [WORD_WIDTH+31:0] total_ext;
  mdu_req_t              mdu_req;
  mdu_status_t           mdu_status;
  logic [WORD_WIDTH-1:0] mdu_result;

  iee_muldiv #(
    .WORD_WIDTH(WORD_WIDTH)
  ) u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mdu_req),
    .a_i      (term_q),
    .b_i      (num_q),
    .result_o (mdu_result),
    .status_o (mdu_status)
  );

  assign char_i.ready = (state_q == ST_IDLE);
  assign accept       = char_i.valid && char_i.ready;
  assign is_digit     = (char_i.char_code >= CharZero) && (char_i.char_code <= CharNine);
  assign is_space     = (char_i.char_code == CharSpace);
  assign is_op        = !is_digit && !is_space;
  assign pend_muldiv  = (op_q == OP_TIMES) || (op_q == OP_DIVIDE);
  assign apply_en     = (accept && is_op) || (state_q == ST_CLOSE);
  assign next_op      = (state_q == ST_CLOSE) ? OP_PLUS : op_code(char_i.char_code);
  assign out_free     = !out_valid_q || result_o.ready;
  assign digit_ext    = WORD_WIDTH'(char_i.char_code - CharZero);
  assign total        = sum_q + term_q;
  assign total_ext    = {32'b0, total};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_op && pend_muldiv) begin
            state_d = ST_BUSY;
          end else if (char_i.is_last) begin
            state_d = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        state_d = pend_muldiv ? ST_BUSY : ST_FINISH;
      end
      ST_BUSY: begin
        if (mdu_status.done) begin
          if (close_q) begin
            state_d = ST_FINISH;
          end else if (last_q) begin
            state_d = ST_CLOSE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    sum_d          = sum_q;
    term_d         = term_q;
    num_d          = num_q;
    op_d           = op_q;
    dz_d           = dz_q;
    last_d         = last_q;
    close_d        = close_q;
    out_valid_d    = out_valid_q && !result_o.ready;
    out_value_d    = out_value_q;
    out_dz_d       = out_dz_q;
    mdu_req.start  = 1'b0;
    mdu_req.is_div = (op_q == OP_DIVIDE);

    if (accept) begin
      last_d = char_i.is_last;
      if (is_digit) begin
        num_d = (num_q << 3) + (num_q << 1) + digit_ext;
      end
    end

    if (apply_en) begin
      case (op_q)
        OP_PLUS: begin
          sum_d  = total;
          term_d = num_q;
        end
        OP_MINUS: begin
          sum_d  = total;
          term_d = ~num_q + 1'b1;
        end
        OP_TIMES, OP_DIVIDE: begin
          mdu_req.start = 1'b1;
          close_d       = (state_q == ST_CLOSE);
        end
        default: begin
        end
      endcase
      op_d  = next_op;
      num_d = '0;
    end

    if ((state_q == ST_BUSY) && mdu_status.done) begin
      term_d = mdu_result;
      dz_d   = dz_q | mdu_status.div_zero;
    end

    if ((state_q == ST_FINISH) && out_free) begin
      out_valid_d = 1'b1;
      out_value_d = total_ext[ValueWidth-1:0];
      out_dz_d    = dz_q;
      sum_d       = '0;
      term_d      = '0;
      num_d       = '0;
      op_d        = OP_PLUS;
      dz_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      term_q      <= '0;
      num_q       <= '0;
      op_q        <= OP_PLUS;
      dz_q        <= 1'b0;
      last_q      <= 1'b0;
      close_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      term_q      <= term_d;
      num_q       <= num_d;
      op_q        <= op_d;
      dz_q        <= dz_d;
      last_q      <= last_d;
      close_q     <= close_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_dz_q    <= out_dz_d;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.value       = out_value_q;
  assign result_o.div_by_zero = out_dz_q;

endmodule
